// ===== hw/rtl/cmt_pkg.sv =====
// Package for the chunked message transport block.
// Store sizes, header flags, item/result codes and the packed item and result types.
// No dependencies.
package cmt_pkg;

  localparam int REQUEST_BYTES  = 256;
  localparam int RESPONSE_BYTES = 256;

  localparam int REQ_AW = $clog2(REQUEST_BYTES);
  localparam int REQ_FW = $clog2(REQUEST_BYTES + 1);
  localparam int RSP_AW = $clog2(RESPONSE_BYTES);
  localparam int RSP_FW = $clog2(RESPONSE_BYTES + 1);

  localparam logic [7:0] FLAG_BEGIN = 8'h40;
  localparam logic [7:0] FLAG_END   = 8'h80;
  localparam logic [7:0] NO_TAG     = 8'hFF;
  localparam logic [15:0] CHUNK_BYTES = 16'd16;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RK_STATUS = 2'd0,
    RK_CHUNK  = 2'd1,
    RK_WORD   = 2'd2
  } rkind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OFFSET = 2'd1,
    ST_LENGTH = 2'd2,
    ST_ID     = 2'd3
  } status_t;

  // Input item, first field in the high bits.
  typedef struct packed {
    logic [63:0] payload_high;
    logic [63:0] payload_low;
    logic [7:0]  header_in;
    logic [15:0] access_length;
    logic [15:0] access_offset;
  } item_t;

  typedef struct packed {
    rkind_t      result_kind;
    status_t     status;
    logic [15:0] byte_count;
    logic [7:0]  header_out;
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic        last;
  } rsl_t;

endpackage

// ===== hw/rtl/chunked_message_transport_top.sv =====
// Top level of the chunked message transport block: stream ports and the
// output register in front of the result channel.
// Depends on cmt_pkg and cmt_seq.
//
// Usage:
//   Items enter on the s_ group; s_tuser carries the item kind (write chunk,
//   read chunk, load response bytes). Results leave on the m_ group;
//   m_tuser carries the result kind and m_tlast marks the final result of
//   an item. One item is in work at a time.
//   Transfers are paced by the byte-wide request and response stores, one
//   byte a cycle through one port; a write with the end mark then also
//   reads each delivered word back out of the request store. Status-only
//   items move no bytes through the stores.
//   The next item is taken while the last result still sits in the output
//   register. When m_tready is low the block holds its result and waits.
//   Reset empties the request and response (no request open, no response)
//   and needs no clearing pass; store contents are undefined until written.
module chunked_message_transport_top
  import cmt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // access_offset, access_length, header_in, payload_low, payload_high
  input  logic [167:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, byte_count, header_out, chunk_low, chunk_high, zero fill
  output logic [159:0] m_tdata,
  // result_kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  item_t item;
  rsl_t  res;
  rsl_t  out_reg;
  logic  emit;
  logic  out_free;
  logic  in_ready;

  assign item     = item_t'(s_tdata);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = in_ready;

  cmt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .in_kind  (kind_t'(s_tuser)),
    .item     (item),
    .emit     (emit),
    .res      (res),
    .out_free (out_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {6'b000000, out_reg.chunk_high, out_reg.chunk_low, out_reg.header_out,
                    out_reg.byte_count, out_reg.status};
  assign m_tuser = out_reg.result_kind;
  assign m_tlast = out_reg.last;

endmodule

// ===== hw/rtl/cmt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cmt_seq.sv =====
// Transfer sequencer: checks each item, moves bytes into and out of the
// request and response stores one per cycle, and builds the results.
// Depends on cmt_pkg and cmt_ram.
module cmt_seq
  import cmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  kind_t in_kind,
  input  item_t item,
  output logic  emit,
  output rsl_t  res,
  input  logic  out_free
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_FETCH = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  kind_t        op;
  logic [127:0] pay;
  logic [3:0]   cnt_m1;
  logic [3:0]   widx;
  logic [3:0]   ridx;
  logic         iss_done;
  logic         rv;
  logic [3:0]   rix;
  logic [127:0] acc;
  logic [127:0] acc_next;
  logic         deliver;

  logic [7:0]        req_tag;
  logic [REQ_FW-1:0] req_fill;
  logic [REQ_FW-1:0] req_base;
  logic [REQ_FW-1:0] tot;
  logic [7:0]        rsp_tag;
  logic [RSP_FW-1:0] rsp_fill;
  logic [RSP_FW-1:0] rsp_sent;
  logic [RSP_FW-1:0] rsp_base;

  // RAM ports
  logic              req_we, rsp_we;
  logic [REQ_AW-1:0] req_waddr, req_raddr;
  logic [RSP_AW-1:0] rsp_waddr, rsp_raddr;
  logic [7:0]        wbyte, req_rdata, rsp_rdata, rbyte;

  // item decode
  logic [15:0]       len;
  logic [4:0]        wn;
  logic [REQ_FW-1:0] wbase;
  logic              id_ok, req_ovf, rsp_ovf;
  logic [RSP_FW-1:0] rsp_rem;
  logic [3:0]        rd_m1;
  logic [REQ_FW-1:0] word_rem;
  logic [3:0]        word_m1;
  logic [REQ_FW-1:0] word_end;
  logic [RSP_FW-1:0] chunk_end;
  logic [7:0]        chunk_hdr;
  logic              fetch_done;

  function automatic rsl_t mk_res(rkind_t k, status_t st, logic [15:0] cnt, logic [7:0] hdr,
                                  logic [63:0] lo, logic [63:0] hi, logic lst);
    rsl_t r;
    r.result_kind = k;
    r.status      = st;
    r.byte_count  = cnt;
    r.header_out  = hdr;
    r.chunk_low   = lo;
    r.chunk_high  = hi;
    r.last        = lst;
    return r;
  endfunction

  assign len     = item.access_length;
  assign wn      = 5'(len[4:0] - 5'd1);
  assign wbase   = item.header_in[6] ? '0 : req_fill;
  assign id_ok   = item.header_in[6] || ({2'b00, item.header_in[5:0]} == req_tag);
  assign req_ovf = ({1'b0, wbase} + (REQ_FW+1)'(wn)) > (REQ_FW+1)'(REQUEST_BYTES);
  assign rsp_ovf = ({1'b0, rsp_fill} + (RSP_FW+1)'(len[4:0])) > (RSP_FW+1)'(RESPONSE_BYTES);
  assign rsp_rem = rsp_fill - rsp_sent;
  assign rd_m1   = (rsp_rem > RSP_FW'(16)) ? 4'd15 : 4'(rsp_rem - RSP_FW'(1));

  assign word_rem  = tot - req_base;
  assign word_m1   = (word_rem > REQ_FW'(8)) ? 4'd7 : 4'(word_rem - REQ_FW'(1));
  assign word_end  = REQ_FW'(req_base + REQ_FW'(cnt_m1) + REQ_FW'(1));
  assign chunk_end = RSP_FW'(rsp_base + RSP_FW'(cnt_m1) + RSP_FW'(1));
  assign chunk_hdr = rsp_tag | ((rsp_base == '0) ? FLAG_BEGIN : 8'h00)
                   | ((chunk_end == rsp_fill) ? FLAG_END : 8'h00);

  assign wbyte     = pay[{widx, 3'b000} +: 8];
  assign req_we    = (state == S_WRITE) && (op == KIND_WRITE);
  assign rsp_we    = (state == S_WRITE) && (op != KIND_WRITE);
  assign req_waddr = REQ_AW'(req_base + REQ_FW'(widx));
  assign rsp_waddr = RSP_AW'(rsp_base + RSP_FW'(widx));
  assign req_raddr = REQ_AW'(req_base + REQ_FW'(ridx));
  assign rsp_raddr = RSP_AW'(rsp_base + RSP_FW'(ridx));
  assign rbyte     = (op == KIND_WRITE) ? req_rdata : rsp_rdata;

  cmt_ram #(.WIDTH(8), .DEPTH(REQUEST_BYTES)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (wbyte),
    .raddr (req_raddr),
    .rdata (req_rdata)
  );

  cmt_ram #(.WIDTH(8), .DEPTH(RESPONSE_BYTES)) u_rsp_ram (
    .clk   (clk),
    .we    (rsp_we),
    .waddr (rsp_waddr),
    .wdata (wbyte),
    .raddr (rsp_raddr),
    .rdata (rsp_rdata)
  );

  // the byte that lands this cycle must be in the result built this cycle
  always_comb begin
    acc_next = acc;
    if (rv) begin
      acc_next[{rix, 3'b000} +: 8] = rbyte;
    end
  end

  assign fetch_done = rv && (rix == cnt_m1);
  assign in_ready   = (state == S_IDLE);
  assign emit       = (state == S_EMIT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_kind != KIND_NONE) begin
          state_next = S_EMIT;
          if (in_kind == KIND_WRITE && item.access_offset == '0 && len != '0
              && len <= CHUNK_BYTES + 16'd1 && id_ok && !req_ovf && wn != '0) begin
            state_next = S_WRITE;
          end
          if (in_kind == KIND_LOAD && len <= CHUNK_BYTES && !rsp_ovf && len != '0) begin
            state_next = S_WRITE;
          end
          if (in_kind == KIND_READ && item.access_offset == '0 && len > CHUNK_BYTES
              && rsp_fill != '0 && rsp_sent < rsp_fill) begin
            state_next = S_FETCH;
          end
        end
      end
      S_WRITE: if (widx == cnt_m1) state_next = S_EMIT;
      S_FETCH: if (fetch_done) state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = (op == KIND_WRITE && deliver && req_base != tot) ? S_FETCH : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      req_tag  <= NO_TAG;
      req_fill <= '0;
      rsp_tag  <= NO_TAG;
      rsp_fill <= '0;
      rsp_sent <= '0;
      rv       <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= in_kind;
            pay      <= {item.payload_high, item.payload_low};
            widx     <= '0;
            ridx     <= '0;
            iss_done <= 1'b0;
            rv       <= 1'b0;
            acc      <= '0;
            unique case (in_kind)
              KIND_WRITE: begin
                deliver <= 1'b0;
                if (item.access_offset != '0) begin
                  req_tag  <= NO_TAG;
                  req_fill <= '0;
                  res <= mk_res(RK_STATUS, ST_OFFSET, '0, '0, '0, '0, 1'b1);
                end else if (len == '0 || len > CHUNK_BYTES + 16'd1) begin
                  req_tag  <= NO_TAG;
                  req_fill <= '0;
                  res <= mk_res(RK_STATUS, ST_LENGTH, '0, '0, '0, '0, 1'b1);
                end else if (!id_ok) begin
                  req_tag  <= NO_TAG;
                  req_fill <= '0;
                  res <= mk_res(RK_STATUS, ST_ID, '0, '0, '0, '0, 1'b1);
                end else if (req_ovf) begin
                  req_tag  <= NO_TAG;
                  req_fill <= '0;
                  res <= mk_res(RK_STATUS, ST_LENGTH, '0, '0, '0, '0, 1'b1);
                end else begin
                  cnt_m1   <= 4'(wn - 5'd1);
                  tot      <= REQ_FW'(wbase + REQ_FW'(wn));
                  deliver  <= item.header_in[7];
                  // delivery reads from the start of the store
                  req_base <= (wn == '0) ? '0 : wbase;
                  res <= mk_res(RK_STATUS, ST_OK, len, '0, '0, '0,
                                !(item.header_in[7] && (wbase != '0 || wn != '0)));
                  if (item.header_in[7]) begin
                    req_tag  <= NO_TAG;
                    req_fill <= '0;
                    rsp_tag  <= {2'b00, item.header_in[5:0]};
                    rsp_fill <= '0;
                    rsp_sent <= '0;
                  end else begin
                    req_tag  <= {2'b00, item.header_in[5:0]};
                    req_fill <= REQ_FW'(wbase + REQ_FW'(wn));
                  end
                end
              end
              KIND_READ: begin
                cnt_m1   <= rd_m1;
                rsp_base <= rsp_sent;
                if (item.access_offset != '0) begin
                  res <= mk_res(RK_STATUS, ST_OFFSET, '0, '0, '0, '0, 1'b1);
                end else if (len <= CHUNK_BYTES) begin
                  res <= mk_res(RK_STATUS, ST_LENGTH, '0, '0, '0, '0, 1'b1);
                end else if (rsp_fill == '0) begin
                  res <= mk_res(RK_CHUNK, ST_OK, '0, '0, '0, '0, 1'b1);
                end else if (rsp_sent >= rsp_fill) begin
                  res <= mk_res(RK_CHUNK, ST_OK, 16'd1, rsp_tag | FLAG_END, '0, '0, 1'b1);
                end
              end
              KIND_LOAD: begin
                cnt_m1   <= 4'(len[4:0] - 5'd1);
                rsp_base <= rsp_fill;
                if (len > CHUNK_BYTES || rsp_ovf) begin
                  res <= mk_res(RK_STATUS, ST_LENGTH, '0, '0, '0, '0, 1'b1);
                end else begin
                  rsp_fill <= RSP_FW'(rsp_fill + RSP_FW'(len[4:0]));
                  res <= mk_res(RK_STATUS, ST_OK, len, '0, '0, '0, 1'b1);
                end
              end
              default: ;
            endcase
          end
        end
        S_WRITE: begin
          widx <= widx + 4'd1;
          if (widx == cnt_m1 && op == KIND_WRITE) begin
            req_base <= '0;
          end
        end
        S_FETCH: begin
          acc <= acc_next;
          rv  <= !iss_done;
          rix <= ridx;
          if (!iss_done) begin
            ridx     <= ridx + 4'd1;
            iss_done <= (ridx == cnt_m1);
          end
          if (fetch_done) begin
            if (op == KIND_WRITE) begin
              res <= mk_res(RK_WORD, ST_OK, 16'(cnt_m1) + 16'd1, '0, acc_next[63:0], '0,
                            word_end == tot);
              req_base <= word_end;
            end else begin
              res <= mk_res(RK_CHUNK, ST_OK, 16'(cnt_m1) + 16'd2, chunk_hdr,
                            acc_next[63:0], acc_next[127:64], 1'b1);
              rsp_sent <= chunk_end;
            end
          end
        end
        S_EMIT: begin
          // set up the next request word
          cnt_m1   <= word_m1;
          ridx     <= '0;
          iss_done <= 1'b0;
          rv       <= 1'b0;
          acc      <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_req_fill_range: assert property (@(posedge clk) disable iff (rst)
    req_fill <= REQ_FW'(REQUEST_BYTES))
    else $error("request fill past store size");

  a_rsp_sent_range: assert property (@(posedge clk) disable iff (rst)
    rsp_sent <= rsp_fill)
    else $error("response sent past fill");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res.result_kind == RK_WORD) |->
      (res.byte_count != '0 && res.byte_count <= 16'd8))
    else $error("delivered word count out of range");

  a_fetch_lane: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && rv) |-> (rix <= cnt_m1))
    else $error("read data landed beyond chunk");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for chunked_message_transport_top: request reassembly,
// word delivery, response loading and chunked readout against an in-bench predictor.
// Depends on cmt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
  import cmt_pkg::*;

  localparam logic [7:0] ID_MASK   = 8'h3F;
  localparam int unsigned RANDOM_ACCESSES = 209;
  localparam int unsigned DRAIN_CYCLES    = 400;

  typedef struct packed {
    kind_t kind;
    item_t item;
  } access_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata  = '0;
  logic [1:0]   s_tuser  = KIND_NONE;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  chunked_message_transport_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  access_t     access_queue[$];
  access_t     next_access;
  rsl_t        expected_results[$];
  int unsigned n_real;
  int unsigned n_total;
  int unsigned issued_count;
  int unsigned taken_count;
  int unsigned phase;
  int unsigned mismatch_count;

  // predictor state
  logic [7:0]   req_mem [REQUEST_BYTES];
  logic [7:0]   req_id;
  int unsigned  req_len;
  logic [7:0]   rsp_mem [RESPONSE_BYTES];
  logic [7:0]   rsp_id;
  int unsigned  rsp_len;
  int unsigned  rsp_done;
  // predictor scratch
  rsl_t         res [34];
  int unsigned  nres;
  kind_t        in_kind;
  item_t        in_item;
  status_t      st;
  logic [7:0]   hdr;
  logic [127:0] payload;
  logic [127:0] chunk;
  logic [63:0]  word;
  int unsigned  nbytes;
  int unsigned  pos;
  int unsigned  cnt;
  int unsigned  idx;
  rsl_t         exp_r;

  function automatic rsl_t make_result(rkind_t rk, status_t s, logic [15:0] n,
                                       logic [7:0] h, logic [63:0] lo, logic [63:0] hi);
    rsl_t r;
    r.result_kind = rk;
    r.status      = s;
    r.byte_count  = n;
    r.header_out  = h;
    r.chunk_low   = lo;
    r.chunk_high  = hi;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic rsl_t status_result(status_t s, logic [15:0] n);
    return make_result(RK_STATUS, s, n, 8'd0, 64'd0, 64'd0);
  endfunction

  function automatic bit draw_percent(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_access(kind_t kd, logic [15:0] ofs, logic [15:0] len, logic [7:0] h);
    access_t a;
    a.kind               = kd;
    a.item.access_offset = ofs;
    a.item.access_length = len;
    a.item.header_in     = h;
    a.item.payload_low   = {$urandom, $urandom};
    a.item.payload_high  = {$urandom, $urandom};
    access_queue.push_back(a);
    if (kd != KIND_NONE) n_real++;
  endtask

  task automatic add_chunk(logic [7:0] h, int unsigned n);
    add_access(KIND_WRITE, 16'd0, 16'(n + 1), h);
  endtask

  task automatic add_message(logic [7:0] id, int unsigned chunks, int unsigned n);
    int unsigned c;
    for (c = 0; c < chunks; c++)
      add_chunk(id | (c == 0 ? FLAG_BEGIN : 8'h00) | (c == chunks - 1 ? FLAG_END : 8'h00),
                n > 16 ? $urandom_range(0, 16) : n);
  endtask

  // Driver: a new transfer is offered once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst) begin
      phase = (n_total == 0) ? 0 : issued_count * 4 / n_total;
      if (!s_tvalid || taken_count == issued_count) begin
        if (access_queue.size() != 0 &&
            !draw_percent(phase == 1 ? 80 : phase == 3 ? 9 : 0)) begin
          next_access = access_queue.pop_front();
          s_tvalid     <= 1'b1;
          s_tuser      <= next_access.kind;
          s_tdata      <= next_access.item;
          issued_count <= issued_count + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !draw_percent(phase == 2 ? 80 : phase == 3 ? 9 : 0);
    end
  end

  // Monitor and predictor.
  always @(posedge clk) begin
    if (rst) begin
      req_id   = NO_TAG;
      req_len  = 0;
      rsp_id   = NO_TAG;
      rsp_len  = 0;
      rsp_done = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d data %h last %b", m_tuser, m_tdata, m_tlast);
          mismatch_count++;
        end else begin
          exp_r = expected_results.pop_front();
          report_field("result_kind", exp_r.result_kind, m_tuser);
          report_field("status", exp_r.status, m_tdata[1:0]);
          report_field("byte_count", exp_r.byte_count, m_tdata[17:2]);
          report_field("header_out", exp_r.header_out, m_tdata[25:18]);
          report_field("chunk_low", exp_r.chunk_low, m_tdata[89:26]);
          report_field("chunk_high", exp_r.chunk_high, m_tdata[153:90]);
          report_field("last", exp_r.last, m_tlast);
        end
      end

      if (s_tvalid && s_tready) begin
        taken_count <= taken_count + 1;
        in_kind = kind_t'(s_tuser);
        in_item = s_tdata;
        payload = {in_item.payload_high, in_item.payload_low};
        nres    = 0;
        case (in_kind)
          KIND_WRITE: begin
            hdr = in_item.header_in;
            st  = ST_OK;
            if (in_item.access_offset != 16'd0) begin
              st = ST_OFFSET;
            end else if (in_item.access_length == 16'd0 ||
                         in_item.access_length > CHUNK_BYTES + 16'd1) begin
              st = ST_LENGTH;
            end else begin
              nbytes = in_item.access_length - 16'd1;
              if (|(hdr & FLAG_BEGIN)) begin
                req_id  = hdr & ID_MASK;
                req_len = 0;
              end else if ((hdr & ID_MASK) != req_id) begin
                // also catches continuation chunks while no request is open
                st = ST_ID;
              end
              if (st == ST_OK && req_len + nbytes > REQUEST_BYTES) st = ST_LENGTH;
            end
            if (st != ST_OK) begin
              req_id  = NO_TAG;
              req_len = 0;
              res[0]  = status_result(st, 16'd0);
              nres    = 1;
            end else begin
              for (idx = 0; idx < nbytes; idx++)
                req_mem[req_len + idx] = payload[8 * idx +: 8];
              req_len = req_len + nbytes;
              res[0]  = status_result(ST_OK, in_item.access_length);
              nres    = 1;
              if (|(hdr & FLAG_END)) begin
                rsp_id   = req_id;
                rsp_len  = 0;
                rsp_done = 0;
                req_id   = NO_TAG;
                for (pos = 0; pos < req_len; pos += 8) begin
                  cnt  = (req_len - pos > 8) ? 8 : req_len - pos;
                  word = '0;
                  for (idx = 0; idx < cnt; idx++)
                    word[8 * idx +: 8] = req_mem[pos + idx];
                  res[nres] = make_result(RK_WORD, ST_OK, 16'(cnt), 8'd0, word, 64'd0);
                  nres++;
                end
                req_len = 0;
              end
            end
          end
          KIND_READ: begin
            nres = 1;
            if (in_item.access_offset != 16'd0) begin
              res[0] = status_result(ST_OFFSET, 16'd0);
            end else if (in_item.access_length < CHUNK_BYTES + 16'd1) begin
              res[0] = status_result(ST_LENGTH, 16'd0);
            end else if (rsp_len == 0) begin
              res[0] = make_result(RK_CHUNK, ST_OK, 16'd0, 8'd0, 64'd0, 64'd0);
            end else if (rsp_done >= rsp_len) begin
              res[0] = make_result(RK_CHUNK, ST_OK, 16'd1, rsp_id | FLAG_END, 64'd0, 64'd0);
            end else begin
              nbytes = (rsp_len - rsp_done > 16) ? 16 : rsp_len - rsp_done;
              hdr    = rsp_id;
              if (rsp_done == 0) hdr = hdr | FLAG_BEGIN;
              chunk = '0;
              for (idx = 0; idx < nbytes; idx++)
                chunk[8 * idx +: 8] = rsp_mem[rsp_done + idx];
              rsp_done = rsp_done + nbytes;
              if (rsp_done == rsp_len) hdr = hdr | FLAG_END;
              res[0] = make_result(RK_CHUNK, ST_OK, 16'(nbytes + 1), hdr,
                                   chunk[63:0], chunk[127:64]);
            end
          end
          KIND_LOAD: begin
            nbytes = in_item.access_length;
            nres   = 1;
            if (nbytes > 16 || rsp_len + nbytes > RESPONSE_BYTES) begin
              res[0] = status_result(ST_LENGTH, 16'd0);
            end else begin
              for (idx = 0; idx < nbytes; idx++)
                rsp_mem[rsp_len + idx] = payload[8 * idx +: 8];
              rsp_len = rsp_len + nbytes;
              res[0]  = status_result(ST_OK, in_item.access_length);
            end
          end
          default: nres = 0;
        endcase
        if (nres != 0) res[nres - 1].last = 1'b1;
        for (idx = 0; idx < nres; idx++) expected_results.push_back(res[idx]);
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned random_start;
    int unsigned c;
    logic [7:0]  id;

    // directed: error paths, empty cases, a short exchange
    add_access(KIND_READ, 16'd0, 16'd17, 8'h00);           // read of empty response
    add_access(KIND_READ, 16'hFFFF, 16'd17, 8'h00);        // bad offset
    add_access(KIND_READ, 16'd0, 16'd16, 8'h00);           // buffer too small
    add_chunk(8'h05, 2);                                   // continuation, nothing open
    add_access(KIND_WRITE, 16'h8000, 16'd3, FLAG_BEGIN);
    add_access(KIND_WRITE, 16'd0, 16'd0, FLAG_BEGIN);
    add_access(KIND_WRITE, 16'd0, 16'd18, FLAG_BEGIN);
    add_access(KIND_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);      // unused kind, no result
    add_chunk(FLAG_BEGIN | FLAG_END | 8'h3F, 0);           // empty request
    add_access(KIND_READ, 16'd0, 16'd17, 8'h00);
    add_chunk(FLAG_BEGIN | 8'h2A, 16);
    add_chunk(8'h2A, 16);
    add_chunk(8'h15 | FLAG_END, 4);                        // id mismatch drops request
    add_chunk(FLAG_BEGIN | 8'h00, 9);
    add_chunk(FLAG_END | 8'h00, 16);                       // 25 bytes, partial last word
    add_access(KIND_LOAD, 16'd0, 16'd17, 8'h00);           // count too large
    add_access(KIND_LOAD, 16'hFFFF, 16'd16, 8'hFF);        // offset ignored on load
    add_access(KIND_LOAD, 16'd0, 16'd0, 8'h00);
    add_access(KIND_LOAD, 16'd0, 16'd5, 8'h00);
    add_access(KIND_READ, 16'd0, 16'hFFFF, 8'h00);
    add_access(KIND_READ, 16'd0, 16'd17, 8'h00);
    add_access(KIND_READ, 16'd0, 16'd17, 8'h00);           // all sent

    random_start = n_real;
    // request store overflow on the 17th full chunk
    for (c = 0; c < 17; c++)
      add_chunk((c == 0 ? FLAG_BEGIN : 8'h00) | (c == 16 ? FLAG_END : 8'h00) | 8'h11, 16);
    // full 256-byte request, delivered as 32 words
    add_message(8'h22, 16, 16);
    // response store filled, then one byte too many, then read out
    for (c = 0; c < 16; c++) add_access(KIND_LOAD, 16'($urandom), 16'd16, 8'($urandom));
    add_access(KIND_LOAD, 16'd0, 16'd1, 8'h00);
    for (c = 0; c < 17; c++) add_access(KIND_READ, 16'd0, 16'($urandom_range(17, 65535)), 8'h00);

    while (n_real < random_start + RANDOM_ACCESSES) begin
      pick = $urandom_range(0, 99);
      id   = 8'($urandom_range(0, 63));
      if (pick < 60) begin
        add_message(id, $urandom_range(1, 4), 17);
        repeat ($urandom_range(0, 3))
          add_access(KIND_LOAD, 16'($urandom), 16'($urandom_range(0, 16)), 8'($urandom));
        repeat ($urandom_range(1, 4))
          add_access(KIND_READ, 16'd0, 16'($urandom_range(17, 65535)), 8'($urandom));
      end else if (pick < 80) begin
        add_chunk(id | FLAG_BEGIN, $urandom_range(0, 16));
        case ($urandom_range(0, 2))
          0: add_chunk((id ^ 8'($urandom_range(1, 63))) | FLAG_END, $urandom_range(0, 16));
          1: add_access(KIND_WRITE, 16'd0, 16'($urandom_range(18, 65535)), id);
          default: add_access(KIND_WRITE, 16'($urandom_range(1, 65535)),
                              16'($urandom_range(1, 17)), id);
        endcase
        // request was dropped, so this one is rejected too
        add_chunk(id | FLAG_END, $urandom_range(0, 16));
      end else begin
        add_access(kind_t'($urandom_range(0, 3)),
                   $urandom_range(0, 1) ? 16'd0 : 16'($urandom),
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom),
                   8'($urandom));
      end
    end
    n_total = access_queue.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (access_queue.size() != 0 || taken_count != n_total ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
